// ----- sv/gps_position_line_parser_assert.svh -----
// ----------------------------------------------------------------------------
// GPS position line parser assertion macros
// Shorthand for the concurrent checks on the parser's stream ports.
// ----------------------------------------------------------------------------
`ifndef GPS_POSITION_LINE_PARSER_ASSERT_SVH
`define GPS_POSITION_LINE_PARSER_ASSERT_SVH

// Check that is switched off while reset is applied.
`define GPL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that also holds while reset is applied.
`define GPL_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gpl_pkg.sv -----
// ----------------------------------------------------------------------------
// GPS position line parser package
// Shared constants, character codes and record types of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gpl_pkg;

	// Coordinate format: DDDMM.FFFFFF at most.
	localparam int FRAC_DIGITS = 6;
	localparam int INT_DIGITS  = 5;
	localparam int FRAC_SLOTS  = 6;

	localparam int INT_BCD_W  = 4 * INT_DIGITS;
	localparam int FRAC_BCD_W = 4 * FRAC_SLOTS;
	localparam int INT_CNT_W  = $clog2(INT_DIGITS + 1);
	localparam int FRAC_CNT_W = $clog2(FRAC_DIGITS + 1);

	// Arithmetic widths of the degree conversion.
	localparam int SCALE   = 1000000;
	localparam int DEG_W   = $clog2(10 ** (INT_DIGITS - 2));
	localparam int MIN_W   = 7;
	localparam int FRAC_W  = $clog2(SCALE);
	localparam int X_W     = $clog2(100 * SCALE);
	localparam int MAG_W   = 30;
	localparam int OUT_W   = 31;

	// Division by 60 as a multiplication by a rounded-up reciprocal.
	localparam int RECIP_SHIFT = 33;
	localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60;
	localparam int RECIP_W = 28;
	localparam int PROD_W  = X_W + RECIP_W;
	localparam int Q_W     = 21;

	// Result status codes.
	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_FIX    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIX  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NODATA = 2'd2;

	localparam int OUT_TDATA_W = STATUS_W + 2 * OUT_W;

	// Character codes.
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	// Header and error texts.
	localparam int HDR_LEN   = 11;
	localparam int HDR_CNT_W = $clog2(HDR_LEN);
	localparam logic [7:0] HDR_TEXT [HDR_LEN] = '{
		8'h2B, 8'h43, 8'h47, 8'h50, 8'h53, 8'h49, 8'h4E, 8'h46, 8'h4F, 8'h3A, 8'h20
	};
	localparam int ERR_LEN   = 5;
	localparam int ERR_CNT_W = $clog2(ERR_LEN);
	localparam logic [7:0] ERR_TEXT [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

	// One coordinate as read from the line.
	typedef struct packed {
		logic                  ok;
		logic [INT_BCD_W-1:0]  int_bcd;
		logic [FRAC_BCD_W-1:0] frac_bcd;
		logic                  neg;
	} coord_rec_t;

	// Everything a newline hands to the conversion pipeline.
	typedef struct packed {
		logic       no_data;
		coord_rec_t lat;
		coord_rec_t lon;
	} line_rec_t;

	// Load enables of the conversion stages.
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
	} stage_en_t;

endpackage

`default_nettype wire

// ----- sv/gpl_parser.sv -----
// ----------------------------------------------------------------------------
// GPS position line parser, character front end
// Matches the header and the error text, splits the comma fields and keeps
// each coordinate as BCD digits until the line ends.
// ----------------------------------------------------------------------------
`default_nettype none

module gpl_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output logic               newline,
	output gpl_pkg::line_rec_t line_rec
);
	import gpl_pkg::*;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_FIELDS = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam logic [1:0] FLD_LAT      = 2'd0;
	localparam logic [1:0] FLD_LAT_HEMI = 2'd1;
	localparam logic [1:0] FLD_LON      = 2'd2;
	localparam logic [1:0] FLD_LON_HEMI = 2'd3;

	// Per-field accumulation state, cleared at the boundaries after the latitude, its hemisphere and the longitude.
	typedef struct packed {
		logic [INT_BCD_W-1:0]  int_bcd;
		logic [INT_CNT_W-1:0]  int_cnt;
		logic [FRAC_BCD_W-1:0] frac_bcd;
		logic [FRAC_CNT_W-1:0] frac_cnt;
		logic                  dot;
		logic                  malf;
		logic                  hneg;
		logic [1:0]            hlen;
	} field_acc_t;

	logic [1:0]           phase_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic [ERR_CNT_W-1:0] err_cnt_q;
	logic                 err_seen_q;
	logic [1:0]           field_q;
	field_acc_t           fa_q;
	coord_rec_t           lat_rec_q;
	coord_rec_t           lon_rec_q;
	logic                 ffe_q;

	logic       is_digit;
	logic [3:0] digit;
	logic       in_fields;
	logic       hemi_neg_now;
	logic       ffe_now;
	logic       err_hit;
	logic       hdr_hit;
	coord_rec_t cur_rec;

	// Classification of the current byte and the field in progress.
	always_comb begin
		is_digit     = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
		digit        = rx_byte[3:0];
		newline      = (rx_byte == CH_NL);
		in_fields    = (phase_q == PH_FIELDS);
		hemi_neg_now = (fa_q.hlen == 2'd1) && fa_q.hneg;
		err_hit      = (int'(err_cnt_q) < ERR_LEN) && (rx_byte == ERR_TEXT[err_cnt_q]);
		hdr_hit      = (int'(hdr_cnt_q) < HDR_LEN) && (rx_byte == HDR_TEXT[hdr_cnt_q]);
		cur_rec.ok       = !fa_q.malf && fa_q.dot && (int'(fa_q.int_cnt) >= 2);
		cur_rec.int_bcd  = fa_q.int_bcd;
		cur_rec.frac_bcd = fa_q.frac_bcd;
		cur_rec.neg      = 1'b0;
		ffe_now = ffe_q || (in_fields && (field_q == FLD_LAT) && (fa_q.int_cnt == '0)
			&& !fa_q.dot && !fa_q.malf);
	end

	// Line summary as seen by a newline arriving now.
	always_comb begin
		line_rec.no_data = err_seen_q || (phase_q == PH_SEARCH) || ffe_now;
		if (in_fields && (field_q == FLD_LAT)) begin
			line_rec.lat = cur_rec;
		end else begin
			line_rec.lat = lat_rec_q;
		end
		if (in_fields && (field_q == FLD_LAT_HEMI)) begin
			line_rec.lat.neg = hemi_neg_now;
		end
		if (in_fields && (field_q == FLD_LON)) begin
			line_rec.lon = cur_rec;
		end else begin
			line_rec.lon = lon_rec_q;
		end
		line_rec.lon.neg = (field_q == FLD_LON_HEMI) && hemi_neg_now;
	end

	// Line state: header search, error search and field splitting.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_SEARCH;
			hdr_cnt_q  <= '0;
			err_cnt_q  <= '0;
			err_seen_q <= 1'b0;
			field_q    <= FLD_LAT;
			fa_q       <= '0;
			lat_rec_q  <= '0;
			lon_rec_q  <= '0;
			ffe_q      <= 1'b0;
		end else if (accept) begin
			if (newline) begin
				phase_q    <= PH_SEARCH;
				hdr_cnt_q  <= '0;
				err_cnt_q  <= '0;
				err_seen_q <= 1'b0;
				field_q    <= FLD_LAT;
				fa_q       <= '0;
				lat_rec_q  <= '0;
				lon_rec_q  <= '0;
				ffe_q      <= 1'b0;
			end else begin
				// Error text anywhere in the line.
				if (err_hit) begin
					if (int'(err_cnt_q) == ERR_LEN - 1) begin
						err_seen_q <= 1'b1;
						err_cnt_q  <= '0;
					end else begin
						err_cnt_q <= err_cnt_q + 1'b1;
					end
				end else begin
					err_cnt_q <= ERR_CNT_W'(rx_byte == CH_E);
				end

				if (phase_q == PH_SEARCH) begin
					// Header search.
					if (hdr_hit) begin
						hdr_cnt_q <= hdr_cnt_q + 1'b1;
						if (int'(hdr_cnt_q) == HDR_LEN - 1) begin
							phase_q <= PH_FIELDS;
							field_q <= FLD_LAT;
							fa_q    <= '0;
						end
					end else begin
						hdr_cnt_q <= HDR_CNT_W'(rx_byte == CH_PLUS);
					end
				end else if (in_fields && (rx_byte != CH_CR)) begin
					if (rx_byte == CH_COMMA) begin
						// Field boundary.
						case (field_q)
							FLD_LAT: begin
								ffe_q     <= ffe_now;
								lat_rec_q <= cur_rec;
								field_q   <= FLD_LAT_HEMI;
								fa_q      <= '0;
							end
							FLD_LAT_HEMI: begin
								lat_rec_q.neg <= hemi_neg_now;
								field_q       <= FLD_LON;
								fa_q          <= '0;
							end
							FLD_LON: begin
								lon_rec_q <= cur_rec;
								field_q   <= FLD_LON_HEMI;
								fa_q      <= '0;
							end
							default: begin
								phase_q <= PH_DONE;
							end
						endcase
					end else if ((field_q == FLD_LAT) || (field_q == FLD_LON)) begin
						// Coordinate character.
						if (is_digit) begin
							if (!fa_q.dot) begin
								if (int'(fa_q.int_cnt) >= INT_DIGITS) begin
									fa_q.malf <= 1'b1;
								end else begin
									fa_q.int_bcd <= {fa_q.int_bcd[INT_BCD_W-5:0], digit};
									fa_q.int_cnt <= fa_q.int_cnt + 1'b1;
								end
							end else if (int'(fa_q.frac_cnt) < FRAC_DIGITS) begin
								for (int j = 0; j < FRAC_SLOTS; j++) begin
									if (int'(fa_q.frac_cnt) == FRAC_SLOTS - 1 - j) begin
										fa_q.frac_bcd[4*j +: 4] <= digit;
									end
								end
								fa_q.frac_cnt <= fa_q.frac_cnt + 1'b1;
							end
						end else if (rx_byte == CH_DOT) begin
							if (fa_q.dot) begin
								fa_q.malf <= 1'b1;
							end else begin
								fa_q.dot <= 1'b1;
							end
						end else begin
							fa_q.malf <= 1'b1;
						end
					end else begin
						// Hemisphere character.
						if (fa_q.hlen == 2'd0) begin
							fa_q.hneg <= (rx_byte == CH_S) || (rx_byte == CH_W);
						end
						if (fa_q.hlen != 2'd2) begin
							fa_q.hlen <= fa_q.hlen + 2'd1;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/gpl_coord_conv.sv -----
// ----------------------------------------------------------------------------
// GPS position line parser, coordinate converter
// Turns DDDMM.FFFFFF BCD digits into signed microdegrees over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gpl_coord_conv (
	input  logic                        clk,
	input  gpl_pkg::stage_en_t          en,
	input  gpl_pkg::coord_rec_t         rec,
	output logic [gpl_pkg::OUT_W-1:0]   value,
	output logic                        is_zero
);
	import gpl_pkg::*;

	logic [DEG_W-1:0]  deg;
	logic [MIN_W-1:0]  mn;
	logic [FRAC_W-1:0] frac;
	logic [X_W-1:0]    x_comb;
	logic [MAG_W-1:0]  degp_comb;

	logic [X_W-1:0]    x_s2;
	logic [MAG_W-1:0]  degp_s2;
	logic              neg_s2;

	logic [PROD_W-1:0] prod;
	logic [OUT_W-1:0]  degs_comb;

	logic [Q_W-1:0]    q_s3;
	logic [OUT_W-1:0]  degs_s3;
	logic              neg_s3;

	// Digits to degrees, whole minutes and minute fraction in millionths.
	always_comb begin
		deg = '0;
		for (int k = 2; k < INT_DIGITS; k++) begin
			deg = deg + DEG_W'(rec.int_bcd[4*k +: 4] * (10 ** (k - 2)));
		end
		mn = MIN_W'(rec.int_bcd[7:4] * 10) + MIN_W'(rec.int_bcd[3:0]);
		frac = '0;
		for (int j = 0; j < FRAC_SLOTS; j++) begin
			frac = frac + FRAC_W'(rec.frac_bcd[4*j +: 4] * (10 ** j));
		end
		if (rec.ok) begin
			x_comb    = X_W'(mn) * X_W'(SCALE) + X_W'(frac);
			degp_comb = MAG_W'(deg) * MAG_W'(SCALE);
		end else begin
			x_comb    = '0;
			degp_comb = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s2) begin
			x_s2    <= x_comb;
			degp_s2 <= degp_comb;
			neg_s2  <= rec.neg;
		end
	end

	// Minutes over sixty by reciprocal multiply; degree part takes its sign.
	always_comb begin
		prod = PROD_W'(x_s2) * PROD_W'(RECIP);
		if (neg_s2) begin
			degs_comb = '0 - OUT_W'(degp_s2);
		end else begin
			degs_comb = OUT_W'(degp_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld_s3) begin
			q_s3    <= prod[RECIP_SHIFT +: Q_W];
			degs_s3 <= degs_comb;
			neg_s3  <= neg_s2;
		end
	end

	// Final signed sum.
	always_comb begin
		if (neg_s3) begin
			value = degs_s3 - OUT_W'(q_s3);
		end else begin
			value = degs_s3 + OUT_W'(q_s3);
		end
		is_zero = (degs_s3 == '0) && (q_s3 == '0);
	end

endmodule

`default_nettype wire

// ----- sv/gps_position_line_parser.sv -----
// ----------------------------------------------------------------------------
// GPS position line parser
// Takes a modem response one ASCII byte per request and, for every newline,
// returns one request with the status and the latitude and longitude of the
// "+CGPSINFO: " line in signed microdegrees (south and west negative, zero
// unless the status is a fix). A byte is taken in every clock cycle unless
// input is held back; the result of an accepted newline passes a line capture
// register, the two conversion stages (the constant multiplies to degrees and
// the reciprocal multiply that divides the minutes by sixty) and the output
// register, from which it is offered. A stalled output
// holds back input only once the capture register, both conversion stages and
// the output register all hold results, that is after four waiting newlines.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_position_line_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // rx_byte[7:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [gpl_pkg::OUT_TDATA_W-1:0]   m_tdata    // status[1:0], latitude[30:0],
	                                                     // longitude[30:0]
);
	import gpl_pkg::*;

	logic       rdy_out;
	logic       rdy_s1;
	logic       rdy_s2;
	logic       rdy_s3;
	logic       accept;
	logic       newline;
	line_rec_t  line_rec;
	stage_en_t  en;

	logic       v_s1;
	line_rec_t  line_s1;
	logic       v_s2;
	logic       no_data_s2;
	logic       v_s3;
	logic       no_data_s3;

	logic [OUT_W-1:0] lat_val;
	logic [OUT_W-1:0] lon_val;
	logic             lat_zero;
	logic             lon_zero;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [OUT_W-1:0]    lat_q;
	logic [OUT_W-1:0]    lon_q;

	// Stage ready chain: a stage moves when it is empty or its successor moves.
	always_comb begin
		rdy_out   = !out_valid_q || m_tready;
		rdy_s3    = !v_s3 || rdy_out;
		rdy_s2    = !v_s2 || rdy_s3;
		rdy_s1    = !v_s1 || rdy_s2;
		s_tready  = rdy_s1;
		accept    = s_tvalid && rdy_s1;
		en.ld_s2  = rdy_s2;
		en.ld_s3  = rdy_s3;
	end

	gpl_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (s_tdata),
		.newline  (newline),
		.line_rec (line_rec)
	);

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept && newline;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// Line record and status flag carried alongside the conversion.
	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			line_s1 <= line_rec;
		end
		if (rdy_s2) begin
			no_data_s2 <= line_s1.no_data;
		end
		if (rdy_s3) begin
			no_data_s3 <= no_data_s2;
		end
	end

	gpl_coord_conv u_lat_conv (
		.clk     (clk),
		.en      (en),
		.rec     (line_s1.lat),
		.value   (lat_val),
		.is_zero (lat_zero)
	);

	gpl_coord_conv u_lon_conv (
		.clk     (clk),
		.en      (en),
		.rec     (line_s1.lon),
		.value   (lon_val),
		.is_zero (lon_zero)
	);

	// Result register: status priority and zeroed coordinates without a fix.
	always_ff @(posedge clk) begin
		if (rdy_out) begin
			if (no_data_s3) begin
				status_q <= ST_NODATA;
				lat_q    <= '0;
				lon_q    <= '0;
			end else if (lat_zero || lon_zero) begin
				status_q <= ST_NOFIX;
				lat_q    <= '0;
				lon_q    <= '0;
			end else begin
				status_q <= ST_FIX;
				lat_q    <= lat_val;
				lon_q    <= lon_val;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {lon_q, lat_q, status_q};

endmodule

`default_nettype wire

// ----- sv/gpl_checker.sv -----
// ----------------------------------------------------------------------------
// GPS position line parser port checker
// Watches the result stream of the parser and flags impossible results.
// ----------------------------------------------------------------------------
`default_nettype none

module gpl_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gpl_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import gpl_pkg::*;

`include "gps_position_line_parser_assert.svh"

	logic [STATUS_W-1:0] st;
	logic [OUT_W-1:0]    lat;
	logic [OUT_W-1:0]    lon;
	logic                is_fix;
	logic                lat_lon_zero;
	logic                stalled;

	// Result fields as laid out on the data bus.
	assign st           = m_tdata[STATUS_W-1:0];
	assign lat          = m_tdata[STATUS_W +: OUT_W];
	assign lon          = m_tdata[STATUS_W + OUT_W +: OUT_W];
	assign is_fix       = (st == ST_FIX);
	assign lat_lon_zero = (lat == '0) && (lon == '0);
	assign stalled      = m_tvalid && !m_tready;

	// Status is one of the three defined codes.
	`GPL_ASSERT(a_status_code, m_tvalid |-> (st <= ST_NODATA), "undefined status code")

	// Coordinates are zero unless the result is a fix.
	`GPL_ASSERT(a_zero_without_fix, (m_tvalid && !is_fix) |-> lat_lon_zero, "stray coordinates")

	// A fix never carries a zero coordinate.
	`GPL_ASSERT(a_fix_nonzero, (m_tvalid && is_fix) |-> (lat != '0 && lon != '0), "zero in a fix")

	// A stalled result stays put.
	`GPL_ASSERT(a_stall_hold, stalled |=> (m_tvalid && $stable(m_tdata)), "stalled result changed")

	// No result is offered while reset is applied.
	`GPL_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result offered in reset")

endmodule

bind gps_position_line_parser gpl_checker u_gpl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
